// ----- rtl/jsu_pkg.sv -----
// Shared types, constants and helper functions for the JSON string unescaper.
// No dependencies; used by every file under rtl/.
package jsu_pkg;

  localparam int unsigned RunDepth = 4;
  localparam int unsigned RunCntW  = 3;

  localparam logic [7:0]  ChrQuote     = 8'h22;
  localparam logic [7:0]  ChrBackslash = 8'h5C;
  localparam logic [7:0]  ChrSlash     = 8'h2F;
  localparam logic [7:0]  ChrU         = 8'h75;
  localparam logic [7:0]  CtrlLimit    = 8'h20;
  localparam logic [15:0] SurrLow      = 16'hD800;
  localparam logic [15:0] SurrHigh     = 16'hDFFF;
  localparam logic [15:0] Utf8Max1     = 16'h007F;
  localparam logic [15:0] Utf8Max2     = 16'h07FF;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_TEXT = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } jsu_mode_e;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } jsu_status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_string;
    logic       end_of_text;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    jsu_status_e status;
    logic        last_of_run;
  } jsu_out_t;

  typedef struct packed {
    jsu_mode_e   mode;
    logic [1:0]  hex_cnt;
    logic [15:0] acc;
  } jsu_state_t;

  typedef struct packed {
    jsu_out_t [RunDepth-1:0] res;
    logic [RunCntW-1:0]      count;
  } jsu_run_t;

  localparam jsu_state_t StateIdle = '{mode: MODE_IDLE, hex_cnt: 2'd0, acc: 16'h0000};

  // bit 4 flags a non-hex byte
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  // bit 8 set: not a single-byte escape letter
  function automatic logic [8:0] escape_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22:   r = 9'h022;
      8'h5C:   r = 9'h05C;
      8'h2F:   r = 9'h02F;
      8'h62:   r = 9'h008;
      8'h66:   r = 9'h00C;
      8'h6E:   r = 9'h00A;
      8'h72:   r = 9'h00D;
      8'h74:   r = 9'h009;
      default: r = 9'h100;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/json_string_unescape_core.sv -----
// Top level of the JSON string unescaper; instantiates jsu_decode, uses jsu_pkg.
// Input register, decode step, run register drained one result per beat.
//
// Takes one byte of a quoted JSON string per input beat and returns its
// unescaped content as UTF-8 result beats, closed by a done or an error beat.
// A byte is taken every cycle as long as each byte gives at most one result
// and the result side does not stall; a byte that gives k results (a \uXXXX
// escape gives up to three, plus an error beat when end_of_text cuts the
// string short) holds the run register until its last result is taken, and
// the next byte stalls behind it, since the run register hands out one
// result per cycle. Result-side stalls hold it further. Bytes that give no
// result (opening quote, backslash, hex digits, idle bytes) still take a
// beat of their own. An input beat reaches its first result through the
// input register, then the run register.
module json_string_unescape_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  jsu_pkg::jsu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jsu_pkg::jsu_out_t out_data_o
);

  logic                               in_valid_q;
  jsu_pkg::jsu_in_t                   in_data_q;
  jsu_pkg::jsu_state_t                state_q, state_d;
  jsu_pkg::jsu_run_t                  run_d;
  jsu_pkg::jsu_out_t [jsu_pkg::RunDepth-1:0] res_q;
  logic [jsu_pkg::RunCntW-1:0]        rem_q;
  logic [1:0]                         rd_q;
  logic                               out_take;
  logic                               run_free;
  logic                               advance;

  assign out_take = out_valid_o && !out_stall_i;
  assign run_free = (rem_q == '0) || (rem_q == jsu_pkg::RunCntW'(1) && !out_stall_i);
  assign advance  = in_valid_q && run_free;
  assign in_stall_o = in_valid_q && !run_free;

  jsu_decode u_decode (
    .in_i    (in_data_q),
    .state_i (state_q),
    .state_o (state_d),
    .run_o   (run_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= jsu_pkg::StateIdle;
      rem_q      <= '0;
      rd_q       <= 2'd0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
        rem_q   <= run_d.count;
        rd_q    <= 2'd0;
      end else if (out_take) begin
        rem_q <= rem_q - jsu_pkg::RunCntW'(1);
        rd_q  <= rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      res_q <= run_d.res;
    end
  end

  assign out_valid_o = (rem_q != '0);

  always_comb begin
    out_data_o             = res_q[rd_q];
    out_data_o.last_of_run = (rem_q == jsu_pkg::RunCntW'(1));
  end

endmodule

// ----- rtl/jsu_decode.sv -----
// One-byte step of the unescaper: parse state plus input beat in, next state
// and the run of up to four results out. Purely combinational; uses jsu_pkg.
module jsu_decode (
  input  jsu_pkg::jsu_in_t    in_i,
  input  jsu_pkg::jsu_state_t state_i,
  output jsu_pkg::jsu_state_t state_o,
  output jsu_pkg::jsu_run_t   run_o
);

  logic [7:0]          c;
  logic [4:0]          hd;
  logic [8:0]          esc;
  logic [15:0]         acc_n;
  logic [7:0]          data [4];
  logic [1:0]          nd;
  logic                tail_v;
  jsu_pkg::jsu_status_e tail_st;

  always_comb begin
    c       = in_i.in_byte;
    hd      = jsu_pkg::hex_value(c);
    esc     = jsu_pkg::escape_map(c);
    acc_n   = {state_i.acc[11:0], hd[3:0]};
    state_o = state_i;
    data[0] = 8'h00;
    data[1] = 8'h00;
    data[2] = 8'h00;
    data[3] = 8'h00;
    nd      = 2'd0;
    tail_v  = 1'b0;
    tail_st = jsu_pkg::ST_ERROR;

    if (in_i.start_of_string) begin
      state_o = jsu_pkg::StateIdle;
      if (c != jsu_pkg::ChrQuote) begin
        tail_v = 1'b1;
      end else begin
        state_o.mode = jsu_pkg::MODE_TEXT;
      end
    end else begin
      case (state_i.mode)
        jsu_pkg::MODE_TEXT: begin
          if (c == jsu_pkg::ChrQuote) begin
            tail_v  = 1'b1;
            tail_st = jsu_pkg::ST_DONE;
            state_o = jsu_pkg::StateIdle;
          end else if (c < jsu_pkg::CtrlLimit) begin
            tail_v  = 1'b1;
            state_o = jsu_pkg::StateIdle;
          end else if (c == jsu_pkg::ChrBackslash) begin
            state_o.mode = jsu_pkg::MODE_ESC;
          end else begin
            data[0] = c;
            nd      = 2'd1;
          end
        end
        jsu_pkg::MODE_ESC: begin
          if (!esc[8]) begin
            data[0]      = esc[7:0];
            nd           = 2'd1;
            state_o.mode = jsu_pkg::MODE_TEXT;
          end else if (c == jsu_pkg::ChrU) begin
            state_o.mode    = jsu_pkg::MODE_HEX;
            state_o.hex_cnt = 2'd0;
            state_o.acc     = 16'h0000;
          end else begin
            tail_v  = 1'b1;
            state_o = jsu_pkg::StateIdle;
          end
        end
        jsu_pkg::MODE_HEX: begin
          if (hd[4]) begin
            tail_v  = 1'b1;
            state_o = jsu_pkg::StateIdle;
          end else if (state_i.hex_cnt == 2'd3) begin
            if (acc_n >= jsu_pkg::SurrLow && acc_n <= jsu_pkg::SurrHigh) begin
              tail_v  = 1'b1;
              state_o = jsu_pkg::StateIdle;
            end else begin
              if (acc_n <= jsu_pkg::Utf8Max1) begin
                data[0] = acc_n[7:0];
                nd      = 2'd1;
              end else if (acc_n <= jsu_pkg::Utf8Max2) begin
                data[0] = {3'b110, acc_n[10:6]};
                data[1] = {2'b10, acc_n[5:0]};
                nd      = 2'd2;
              end else begin
                data[0] = {4'b1110, acc_n[15:12]};
                data[1] = {2'b10, acc_n[11:6]};
                data[2] = {2'b10, acc_n[5:0]};
                nd      = 2'd3;
              end
              state_o = '{mode: jsu_pkg::MODE_TEXT, hex_cnt: 2'd0, acc: 16'h0000};
            end
          end else begin
            state_o.hex_cnt = state_i.hex_cnt + 2'd1;
            state_o.acc     = acc_n;
          end
        end
        default: ;
      endcase
    end

    // text ran out with the string still open
    if (in_i.end_of_text && state_o.mode != jsu_pkg::MODE_IDLE) begin
      tail_v  = 1'b1;
      tail_st = jsu_pkg::ST_ERROR;
      state_o = jsu_pkg::StateIdle;
    end

    for (int i = 0; i < jsu_pkg::RunDepth; i++) begin
      if (3'(i) < {1'b0, nd}) begin
        run_o.res[i] = '{out_byte: data[i], status: jsu_pkg::ST_DATA, last_of_run: 1'b0};
      end else begin
        run_o.res[i] = '{out_byte: 8'h00, status: tail_st, last_of_run: 1'b0};
      end
    end
    run_o.count = {1'b0, nd} + {2'b00, tail_v};
  end

endmodule

// ----- rtl/jsu_checker.sv -----
// Port-level checks for json_string_unescape_core, attached by bind below.
// Uses jsu_pkg for the status codes.
module jsu_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input jsu_pkg::jsu_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input jsu_pkg::jsu_out_t out_data_o
);

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // done and error always close the run of their byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != jsu_pkg::ST_DATA |-> out_data_o.last_of_run)
    else $error("done/error beat not last of run");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != jsu_pkg::ST_DATA |-> out_data_o.out_byte == 8'h00)
    else $error("done/error beat carries a byte");

  // input only waits behind pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
